// File: hw/rtl/adv_pkg.sv
// shared constants, types and helper functions for the ascii date validator
package adv_pkg;

   localparam int unsigned POS_BITS   = 4;
   localparam int unsigned DATE_LEN   = 8;
   localparam int unsigned POS_SAT    = 9;
   localparam int unsigned YEAR_END   = 4;
   localparam int unsigned MONTH_END  = 6;
   localparam int unsigned YEAR_DIGS  = 4;
   localparam int unsigned FIELD_DIGS = 2;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef logic [3:0] digit_type;
   typedef logic [POS_BITS-1:0] pos_type;
   typedef digit_type [YEAR_DIGS-1:0] year_type;
   typedef digit_type [FIELD_DIGS-1:0] field_type;

   // two decimal digits to binary, 0..99
   function automatic logic [6:0] dec2(input digit_type hi, input digit_type lo);
      logic [6:0] h;
      h = {3'b000, hi};
      return (h << 3) + (h << 1) + {3'b000, lo};
   endfunction

   // two-digit number divisible by 4: (10*hi + lo) mod 4 == (2*hi + lo) mod 4
   function automatic logic div4(input digit_type hi, input digit_type lo);
      logic [1:0] s;
      s = {hi[0], 1'b0} + lo[1:0];
      return s == 2'b00;
   endfunction

   // gregorian leap year from four decimal digits, most significant first
   function automatic logic leap_year(input year_type y);
      logic low_zero;
      low_zero = (y[1] == 4'd0) && (y[0] == 4'd0);
      return (div4(y[1], y[0]) && !low_zero) || (low_zero && div4(y[3], y[2]));
   endfunction

   // days in a non-leap month, zero for codes that are not months
   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// File: hw/rtl/adv_req_if.sv
// character channel into the date validator
interface adv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// File: hw/rtl/adv_rsp_if.sv
// result channel out of the date validator
interface adv_rsp_if;
   logic valid;
   logic ready;
   logic date_valid;

   modport source (output valid, output date_valid, input ready);
   modport sink   (input valid, input date_valid, output ready);
endinterface

// File: hw/rtl/ascii_date_validator.sv
// ascii date validator top level: checks a YYYYMMDD character stream
//
// Takes one ASCII character per req transaction, with is_last marking the
// end of a string, and gives one rsp transaction per string carrying
// date_valid: set only when the string is exactly eight decimal digits that
// form a gregorian date (month 1..12, day within the month, leap february).
// A character is taken every cycle; the block keeps one character in an
// input register and one result in an output register, so the result of a
// string reaches rsp when its last character leaves the input register,
// and its rsp transaction can complete at the following edge when rsp is
// not stalled. The only thing that slows the character stream is a full
// output register: while a finished result waits, a last character of the
// next string stays in the input register, but ordinary characters still
// pass. req ready depends combinationally on rsp ready through that path.
// After each result the accumulated state returns to its reset value.
module ascii_date_validator (
   input logic clock,
   input logic reset,
   adv_req_if.sink   req_if,
   adv_rsp_if.source rsp_if
);
   import adv_pkg::*;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;

   // string state
   pos_type   pos_ff, pos_in;
   year_type  year_ff, year_in;
   field_type month_ff, month_in;
   field_type day_ff, day_in;
   logic      bad_ff, bad_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_date_ff, rsp_date_in;

   logic      out_free;
   logic      s1_adv;
   logic      req_fire;
   logic      is_digit;
   digit_type dig;
   pos_type   pos_upd;
   year_type  year_upd;
   field_type month_upd;
   field_type day_upd;
   logic      bad_upd;
   logic [6:0] mval;
   logic [6:0] dval;
   logic [4:0] lim;
   logic       month_ok;
   logic       day_ok;
   logic       result;

   // handshake: input stage moves on unless it holds a last character and
   // the result register cannot take its result
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign s1_adv        = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_if.ready  = !s1_valid_ff || s1_adv;
   assign req_fire      = req_if.valid && req_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.date_valid = rsp_date_ff;

   // per-character update
   assign is_digit = (s1_char_ff >= CHAR_ZERO) && (s1_char_ff <= CHAR_NINE);
   assign dig      = s1_char_ff[3:0];

   always_comb begin
      year_upd  = year_ff;
      month_upd = month_ff;
      day_upd   = day_ff;
      if (is_digit) begin
         if (pos_ff < POS_BITS'(YEAR_END)) begin
            year_upd = {year_ff[YEAR_DIGS-2:0], dig};
         end else if (pos_ff < POS_BITS'(MONTH_END)) begin
            month_upd = {month_ff[FIELD_DIGS-2:0], dig};
         end else if (pos_ff < POS_BITS'(DATE_LEN)) begin
            day_upd = {day_ff[FIELD_DIGS-2:0], dig};
         end
      end
   end

   // position saturates one past the date length
   assign pos_upd = (pos_ff < POS_BITS'(POS_SAT)) ? pos_ff + pos_type'(1) : pos_ff;
   assign bad_upd = bad_ff || !is_digit;

   // date check on the updated fields
   assign mval     = dec2(month_upd[1], month_upd[0]);
   assign dval     = dec2(day_upd[1], day_upd[0]);
   assign month_ok = (mval >= 7'd1) && (mval <= 7'd12);

   always_comb begin
      lim = month_len(mval[3:0]);
      if (mval == 7'd2 && leap_year(year_upd)) begin
         lim = lim + 5'd1;
      end
   end

   assign day_ok = (dval >= 7'd1) && (dval <= {2'b00, lim});
   assign result = (pos_upd == POS_BITS'(DATE_LEN)) && !bad_upd && month_ok && day_ok;

   // next-state selection
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      pos_in       = pos_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_date_in  = rsp_date_ff;

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_adv) begin
         if (s1_last_ff) begin
            // end of string: report and start over
            pos_in       = '0;
            year_in      = '0;
            month_in     = '0;
            day_in       = '0;
            bad_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_date_in  = result;
         end else begin
            pos_in   = pos_upd;
            year_in  = year_upd;
            month_in = month_upd;
            day_in   = day_upd;
            bad_in   = bad_upd;
         end
      end
   end

   // control and string state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_char_ff <= req_if.char_code;
         s1_last_ff <= req_if.is_last;
      end
      rsp_date_ff <= rsp_date_in;
   end

`ifndef NO_ASSERTIONS
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_BITS'(POS_SAT))
      else $error("position counter beyond saturation");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (pos_ff == '0 && !bad_ff))
      else $error("string state not cleared after last character");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_last_ff))
      else $error("result raised without a last character");

   a_month_order: assert property (@(posedge clock) disable iff (reset)
      (pos_ff < POS_BITS'(YEAR_END + 1)) |-> (month_ff == '0 && day_ff == '0))
      else $error("month or day digits taken before the year");
`endif

endmodule

// File: bench/testbench.sv
// testbench for the ascii date validator: scoreboard class, stimulus tasks and top module
`timescale 1ns / 100ps

module testbench;
   import adv_pkg::*;

   localparam int unsigned CHAR_TARGET = 1950;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_AT    = 90;
   localparam int unsigned STEADY_FROM = 150;
   localparam int unsigned STEADY_TO   = 175;
   localparam int unsigned SETTLE_CYCLES = 8;

   // ------------------------------------------------------------------
   // date predictor and verdict store
   // ------------------------------------------------------------------
   class date_verdict_board;
      pos_type     chars_seen;
      logic [13:0] year_val;
      logic [6:0]  month_val;
      logic [6:0]  day_val;
      bit          bad_char;
      int unsigned days_in_month[12];
      bit          verdicts_due[$];
      int unsigned fail_count;

      function new();
         days_in_month = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         fail_count    = 0;
         clear_string();
      endfunction

      function void clear_string();
         chars_seen = '0;
         year_val   = '0;
         month_val  = '0;
         day_val    = '0;
         bad_char   = 1'b0;
      endfunction

      function bit is_leap(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function bit date_in_range();
         int unsigned m;
         int unsigned d;
         int unsigned lim;
         m = 32'(month_val);
         d = 32'(day_val);
         if (m < 1 || m > 12) return 1'b0;
         lim = days_in_month[m-1];
         if (m == 2 && is_leap(32'(year_val))) lim++;
         return (d >= 1) && (d <= lim);
      endfunction

      // fold one accepted character into the string state
      function void note_char(logic [7:0] code, logic last);
         bit         is_digit;
         logic [3:0] digit_val;
         is_digit  = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
         digit_val = 4'(code - CHAR_ZERO);
         if (!is_digit)
            bad_char = 1'b1;
         else if (chars_seen < YEAR_END)
            year_val = year_val * 14'd10 + 14'(digit_val);
         else if (chars_seen < MONTH_END)
            month_val = month_val * 7'd10 + 7'(digit_val);
         else if (chars_seen < DATE_LEN)
            day_val = day_val * 7'd10 + 7'(digit_val);
         if (chars_seen < POS_SAT) chars_seen = chars_seen + pos_type'(1);
         if (last) begin
            verdicts_due.push_back((chars_seen == DATE_LEN) && !bad_char && date_in_range());
            clear_string();
         end
      endfunction

      task flag_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      task check_result(logic got);
         bit want;
         if (verdicts_due.size() == 0) begin
            flag_mismatch($sformatf("result date_valid=%b with no string pending", got));
         end else begin
            want = verdicts_due.pop_front();
            if (got !== want)
               flag_mismatch($sformatf("date_valid=%b, predicted %b", got, want));
         end
      endtask

      function int unsigned pending();
         return verdicts_due.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------
   logic clock;
   logic reset;

   adv_req_if req_bus ();
   adv_rsp_if rsp_bus ();

   ascii_date_validator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   date_verdict_board board = new();

   int unsigned chars_sent   = 0;
   int unsigned strings_done = 0;
   int unsigned cycle_count  = 0;
   bit          steady       = 1'b0;   // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // idle lengths: mostly back to back, some short gaps, a few long ones
   // ------------------------------------------------------------------
   function automatic int unsigned idle_span();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] non_digit();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c >= CHAR_ZERO && c <= CHAR_NINE);
      return c;
   endfunction

   // ------------------------------------------------------------------
   // character driver: one req transaction per call, called at a rising edge
   // ------------------------------------------------------------------
   task automatic send_char(input logic [7:0] code, input logic last);
      int unsigned gap;
      gap = idle_span();
      // only drop valid when there really is a gap, so a back-to-back
      // transaction never sees valid lowered and raised in one step
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= code;
      req_bus.is_last   <= last;
      do @(posedge clock);
      while (req_bus.ready !== 1'b1);
      board.note_char(code, last);
      chars_sent++;
   endtask

   task automatic send_string(input logic [7:0] text[$]);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   // hold the sender off until every pending verdict has been returned;
   // pending count is read on the falling edge, away from the checker
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock);
      while (board.pending() != 0);
      @(posedge clock);
   endtask

   function automatic void text_chars(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   // ------------------------------------------------------------------
   // random string: mostly well-formed dates with random content, the
   // rest corrupted, truncated, padded or plain noise
   // ------------------------------------------------------------------
   function automatic void random_string(ref logic [7:0] q[$]);
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      if (r < 20)      y = $urandom_range(0, 99) * 100;   // century years
      else if (r < 50) y = $urandom_range(0, 2499) * 4;   // leap candidates
      else             y = $urandom_range(0, 9999);
      r = $urandom_range(0, 99);
      if (r < 85)      m = $urandom_range(1, 12);
      else if (r < 90) m = 0;
      else if (r < 95) m = 13;
      else             m = $urandom_range(14, 99);
      if (r < 85 && $urandom_range(0, 3) == 0) m = 2;      // lean on february
      r = $urandom_range(0, 99);
      if (r < 60)      d = $urandom_range(1, 27);
      else if (r < 88) d = $urandom_range(28, 31);
      else if (r < 93) d = 0;
      else if (r < 97) d = 32;
      else             d = $urandom_range(33, 99);
      q.delete();
      text_chars(q, $sformatf("%04d%02d%02d", y, m, d));
      r = $urandom_range(0, 99);
      if (r < 65) begin
         // untouched date
      end else if (r < 75) begin
         q[$urandom_range(0, 7)] = non_digit();
      end else if (r < 82) begin
         n = $urandom_range(1, 7);
         while (q.size() > n) void'(q.pop_back());
      end else if (r < 89) begin
         n = $urandom_range(1, 6);
         repeat (n) q.push_back($urandom_range(0, 1) ? 8'(CHAR_ZERO + $urandom_range(0, 9))
                                                     : 8'($urandom_range(0, 255)));
      end else begin
         q.delete();
         n = $urandom_range(1, 12);
         repeat (n) q.push_back($urandom_range(0, 1) ? 8'(CHAR_ZERO + $urandom_range(0, 9))
                                                     : 8'($urandom_range(0, 255)));
      end
   endfunction

   // ------------------------------------------------------------------
   // result side: random stalls, checked at each rsp transaction
   // ------------------------------------------------------------------
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_span();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_result(rsp_bus.date_valid);
   end

   // watchdog: generous bound over the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                  board.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [7:0] text[$];
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.char_code <= '0;
      req_bus.is_last   <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: year zero counts as leap so feb 29 passes
      text.delete();
      text_chars(text, "00000229");
      send_string(text);
      // directed: all-nines year and the last day of the year
      text.delete();
      text_chars(text, "99991231");
      send_string(text);
      // directed: one-character strings on the digit boundaries, nul and
      // all ones; each is both too short and a bad character
      text = '{8'h00};
      send_string(text);
      text = '{8'hFF};
      send_string(text);
      text = '{CHAR_ZERO - 8'd1};
      send_string(text);
      text = '{CHAR_NINE + 8'd1};
      send_string(text);

      // random part; zero and out-of-range month and day, wrong lengths
      // and stray characters are all weighted into the generator
      while (chars_sent < CHAR_TARGET) begin
         random_string(text);
         if (strings_done == DRAIN_AT) wait_results_drained();
         steady = (strings_done >= STEADY_FROM) && (strings_done < STEADY_TO);
         send_string(text);
         strings_done++;
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      do @(negedge clock);
      while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/adv_pkg.sv
hw/rtl/adv_req_if.sv
hw/rtl/adv_rsp_if.sv
hw/rtl/ascii_date_validator.sv
bench/testbench.sv
